// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/pkh_pkg.sv =====
`default_nettype none
package pkh_pkg;
	localparam int MaxKeyBytes = 64;
	localparam int DigestBytes = 20;
	localparam int KeyW = 7;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ROUND,
		ST_FOLD,
		ST_XOR,
		ST_OUT,
		ST_CLEAR
	} state_t;

	localparam logic [31:0] H0 = 32'h67452301;
	localparam logic [31:0] H1 = 32'hEFCDAB89;
	localparam logic [31:0] H2 = 32'h98BADCFE;
	localparam logic [31:0] H3 = 32'h10325476;
	localparam logic [31:0] H4 = 32'hC3D2E1F0;

	function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
		rotl = (x << n) | (x >> (32 - n));
	endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/pkh_if.sv =====
`default_nettype none
interface pkh_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] phrase_byte;
	logic       has_byte;
	logic       end_of_phrase;
	modport source (output valid, phrase_byte, has_byte, end_of_phrase, input ready);
	modport sink (input valid, phrase_byte, has_byte, end_of_phrase, output ready);
endinterface

interface pkh_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] key_byte;
	logic       last_key_byte;
	modport source (output valid, key_byte, last_key_byte, input ready);
	modport sink (input valid, key_byte, last_key_byte, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/passphrase_key_hasher.sv =====
// A byte that leaves its chunk open is taken with ready staying high. A byte that closes a
// chunk holds ready low while each 64-byte SHA-1 block is hashed (a read lead-in, the byte
// loads, 80 rounds, a fold), one block while key plus chunk fit in 55 bytes and two above,
// then while the digest is XORed into the key, all on the one shared round unit.
// At the phrase end the key bytes go out, each held until taken, then a clear sweep zeroes the key store.
// Reset (arst_n low, asynchronous) sets key_bytes=32, clears control, then sweeps the key store to zero with ready low.
`default_nettype none
`include "assert_macros.svh"
module passphrase_key_hasher #(
	parameter int MAX_KEY_BYTES = pkh_pkg::MaxKeyBytes
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [pkh_pkg::KeyW-1:0] cfg_wdata,
	pkh_in_if.sink                    in_ch,
	pkh_out_if.source                 out_ch
);
	import pkh_pkg::*;

	localparam int KIW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
	localparam logic [KeyW-1:0] MaxLen = KeyW'(MAX_KEY_BYTES);

	// Key store: a small memory, one byte read and one written per cycle.
	logic [7:0] key_mem [MAX_KEY_BYTES];
	logic [7:0] chunk_q [DigestBytes];

	state_t state_q, state_d;
	logic [KeyW-1:0] key_bytes_q;
	logic [4:0] fill_q;
	logic [KIW-1:0] xpos_q;
	logic [KeyW-1:0] len_q;        // key length frozen for the current hash
	logic [7:0] total_q;           // message length in bytes
	logic [1:0] blk_q;             // current 64-byte block
	logic [1:0] nblk_q;
	logic [6:0] cnt_q;             // byte-in-block / round / digest counter
	logic [31:0] word_q;           // byte assembly for the schedule load
	logic [31:0] w_q [16];
	logic [31:0] h_q [5];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [7:0] key_rd_q;          // registered key memory read
	logic [KIW-1:0] oidx_q;
	logic last_q;                  // end marker pending after the hash
	logic out_valid_q;
	logic out_last_q;
	logic [7:0] out_byte_q;
	logic fresh_q;                 // key_rd_q holds valid data for oidx_q

	// Active key length: 0 reads as 1, above the maximum as the maximum.
	logic [KeyW-1:0] act_len;
	always_comb begin
		priority if (key_bytes_q == '0) act_len = KeyW'(1);
		else if (key_bytes_q > MaxLen) act_len = MaxLen;
		else act_len = key_bytes_q;
	end

	// Message byte at position p of the padded message.
	logic [8:0] mpos;
	logic [7:0] mbyte;
	logic [10:0] bitlen;
	assign mpos = {1'b0, blk_q, cnt_q[5:0]};
	assign bitlen = {total_q, 3'b000};
	always_comb begin
		if (mpos < 9'(len_q)) mbyte = key_rd_q;
		else if (mpos < 9'(total_q)) mbyte = chunk_q[5'(mpos - 9'(len_q))];
		else if (mpos == 9'(total_q)) mbyte = 8'h80;
		else if (blk_q == nblk_q - 2'd1 && cnt_q[5:0] == 6'd62) mbyte = {5'b0, bitlen[10:8]};
		else if (blk_q == nblk_q - 2'd1 && cnt_q[5:0] == 6'd63) mbyte = bitlen[7:0];
		else mbyte = 8'h00;
	end

	// Key memory read address (read data registered for the next cycle).
	logic [KIW-1:0] rd_addr;
	logic [8:0] next_pos;
	assign next_pos = mpos + 9'd1;
	always_comb begin
		unique case (state_q)
			ST_LOAD: rd_addr = KIW'(next_pos);
			ST_XOR:  rd_addr = xpos_q;
			ST_OUT:  rd_addr = oidx_q;
			default: rd_addr = '0;
		endcase
	end
	always_ff @(posedge clk) key_rd_q <= key_mem[rd_addr];

	// Shared SHA-1 round unit.
	logic [31:0] f, k, t, wnext, wcur;
	logic [6:0] rnd;
	assign rnd = cnt_q;
	assign wnext = rotl(w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0], 1);
	assign wcur = (rnd < 7'd16) ? w_q[0] : wnext;
	always_comb begin
		priority if (rnd < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q); k = 32'h5A827999;
		end else if (rnd < 7'd40) begin
			f = b_q ^ c_q ^ d_q; k = 32'h6ED9EBA1;
		end else if (rnd < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q); k = 32'h8F1BBCDC;
		end else begin
			f = b_q ^ c_q ^ d_q; k = 32'hCA62C1D6;
		end
	end
	assign t = rotl(a_q, 5) + f + e_q + k + wcur;

	// Digest byte for the XOR pass, indexed by cnt_q halved.
	logic [31:0] dword;
	logic [7:0] dbyte;
	assign dword = h_q[3'(cnt_q[5:3])];
	always_comb begin
		unique case (cnt_q[2:1])
			2'd0: dbyte = dword[31:24];
			2'd1: dbyte = dword[23:16];
			2'd2: dbyte = dword[15:8];
			default: dbyte = dword[7:0];
		endcase
	end

	logic in_acc;
	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_acc = in_ch.valid && in_ch.ready;
	logic [4:0] fill_inc;
	assign fill_inc = fill_q + 5'(in_ch.has_byte);

	// Next state.
	logic start_hash;
	assign start_hash = (fill_inc == 5'(DigestBytes)) || (in_ch.end_of_phrase && fill_inc != '0);
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_acc) begin
				if (start_hash) state_d = ST_LOAD;
				else if (in_ch.end_of_phrase) state_d = ST_OUT;
			end
			ST_LOAD: if (cnt_q == 7'd63) state_d = ST_ROUND;
			ST_ROUND: if (cnt_q == 7'd79) state_d = ST_FOLD;
			ST_FOLD: state_d = (blk_q == nblk_q - 2'd1) ? ST_XOR : ST_LOAD;
			ST_XOR: if (cnt_q == 7'(2 * DigestBytes - 1))
				state_d = last_q ? ST_OUT : ST_IDLE;
			ST_OUT: if (out_ch.ready && out_valid_q && out_last_q) state_d = ST_CLEAR;
			ST_CLEAR: if (oidx_q == KIW'(MAX_KEY_BYTES - 1)) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Leave reset through the clearing sweep so the key store starts at zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_CLEAR;
		else state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) key_bytes_q <= KeyW'(32);
		else if (cfg_we) key_bytes_q <= cfg_wdata;
	end

	// Datapath and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0; xpos_q <= '0; cnt_q <= '0; blk_q <= '0; nblk_q <= 2'd1;
			len_q <= KeyW'(1); total_q <= '0; last_q <= 1'b0; oidx_q <= '0;
			out_valid_q <= 1'b0; out_last_q <= 1'b0; fresh_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_acc) begin
					if (in_ch.has_byte) chunk_q[fill_q] <= in_ch.phrase_byte;
					fill_q <= fill_inc;
					last_q <= in_ch.end_of_phrase;
					cnt_q <= '0; blk_q <= '0; oidx_q <= '0; fresh_q <= 1'b0;
					len_q <= act_len;
					total_q <= 8'(act_len) + 8'(fill_inc);
					nblk_q <= ((8'(act_len) + 8'(fill_inc) + 8'd8) >= 8'd128) ? 2'd3 :
						((8'(act_len) + 8'(fill_inc) + 8'd8) >= 8'd64) ? 2'd2 : 2'd1;
					if (start_hash) begin
						a_q <= H0; b_q <= H1; c_q <= H2; d_q <= H3; e_q <= H4;
						h_q[0] <= H0; h_q[1] <= H1; h_q[2] <= H2; h_q[3] <= H3; h_q[4] <= H4;
						cnt_q <= 7'h7F;   // a key memory read lead-in first
					end
				end
				ST_LOAD: begin
					// advance one byte a cycle; shift a finished word into the schedule
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q != 7'h7F) begin
						word_q <= {word_q[23:0], mbyte};
						if (cnt_q[1:0] == 2'd3) begin
							for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
							w_q[15] <= {word_q[23:0], mbyte};
						end
					end
					if (cnt_q[5:0] == 6'd63 && cnt_q != 7'h7F) cnt_q <= '0;
				end
				ST_ROUND: begin
					e_q <= d_q; d_q <= c_q; c_q <= rotl(b_q, 30); b_q <= a_q; a_q <= t;
					for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
					w_q[15] <= wcur;
					cnt_q <= cnt_q + 7'd1;
				end
				ST_FOLD: begin
					h_q[0] <= h_q[0] + a_q; h_q[1] <= h_q[1] + b_q; h_q[2] <= h_q[2] + c_q;
					h_q[3] <= h_q[3] + d_q; h_q[4] <= h_q[4] + e_q;
					a_q <= h_q[0] + a_q; b_q <= h_q[1] + b_q; c_q <= h_q[2] + c_q;
					d_q <= h_q[3] + d_q; e_q <= h_q[4] + e_q;
					blk_q <= blk_q + 2'd1;
					cnt_q <= (blk_q == nblk_q - 2'd1) ? 7'd0 : 7'h7F;
					if (blk_q == nblk_q - 2'd1 && 7'(xpos_q) >= len_q) xpos_q <= '0;
				end
				ST_XOR: begin
					// even cycle: read key byte; odd cycle: write XOR and advance
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q[0]) begin
						xpos_q <= (7'(xpos_q) + 7'd1 >= len_q) ? '0 : xpos_q + KIW'(1);
					end
					if (cnt_q == 7'(2 * DigestBytes - 1)) begin
						fill_q <= '0; cnt_q <= '0;
					end
				end
				ST_OUT: begin
					// read data is registered behind the index; hold output until taken
					if (!out_valid_q || out_ch.ready) begin
						if (fresh_q && !(out_valid_q && out_last_q)) begin
							out_valid_q <= 1'b1;
							out_byte_q <= key_rd_q;
							out_last_q <= (7'(oidx_q) + 7'd1 == act_len);
							oidx_q <= oidx_q + KIW'(1);
							fresh_q <= 1'b0;
						end else begin
							out_valid_q <= 1'b0;
							fresh_q <= 1'b1;
							if (out_valid_q && out_last_q) begin
								oidx_q <= '0; out_last_q <= 1'b0;
							end
						end
					end
				end
				ST_CLEAR: begin
					oidx_q <= oidx_q + KIW'(1);
					if (oidx_q == KIW'(MAX_KEY_BYTES - 1)) begin
						fill_q <= '0; xpos_q <= '0; last_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// Key memory write: XOR pass and clearing sweep.
	always_ff @(posedge clk) begin
		if (state_q == ST_XOR && cnt_q[0]) key_mem[xpos_q] <= key_rd_q ^ dbyte;
		else if (state_q == ST_CLEAR) key_mem[oidx_q] <= 8'h00;
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.key_byte = out_byte_q;
	assign out_ch.last_key_byte = out_last_q;

	`ASSERT_IMPL(a_busy_ready, clk, arst_n, state_q != ST_IDLE, !in_ch.ready, "ready while busy")
	`ASSERT_IMPL(a_out_state, clk, arst_n, out_valid_q, state_q == ST_OUT, "output outside OUT")
	`ASSERT_IMPL(a_fill_max, clk, arst_n, state_q == ST_IDLE, fill_q < 5'(DigestBytes), "fill overflow")
	`ASSERT_NEXT(a_xor_pos, clk, arst_n, state_q == ST_IDLE, 7'(xpos_q) < 7'(MAX_KEY_BYTES), "bad xor pos")
endmodule
`default_nettype wire
